@@ rtl/core/adc_channel_scan_sequencer_macros.svh @@
// Assertion macros for the ADC channel scan sequencer checker.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ADC_CHANNEL_SCAN_SEQUENCER_MACROS_SVH
`define ADC_CHANNEL_SCAN_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/acss_pkg.sv @@
// Shared types and constants for the ADC channel scan sequencer.
// No dependencies; imported by the sequencer and its checker.
`timescale 1ns / 1ps

package acss_pkg;

  localparam int DEFAULT_CHANNELS    = 8;
  localparam int DEFAULT_MAX_SAMPLES = 64;

  // Fixed field widths of the transaction ports.
  localparam int MASK_W   = 8;
  localparam int SAMPLE_W = 10;
  localparam int CHAN_W   = 3;
  localparam int INDEX_W  = 6;
  localparam int SPC_W    = 7;
  // Wide enough for any sample count up to 256.
  localparam int CNT_W    = 9;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_SAMPLES_PER_CHANNEL = 1'b0;
  localparam logic [SPC_W-1:0] SPC_RESET = 7'd16;

  typedef enum logic {
    MODE_START  = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_t;

  typedef struct packed {
    logic                start_conversion;
    logic [CHAN_W-1:0]   next_channel;
    logic                write_enable;
    logic [CHAN_W-1:0]   write_channel;
    logic [INDEX_W-1:0]  write_index;
    logic [SAMPLE_W-1:0] write_data;
    logic                all_ready;
  } result_t;

endpackage

@@ rtl/core/adc_channel_scan_sequencer.sv @@
// Round-robin ADC scan sequencer: picks channels, tracks fill positions, reports completion.
// Depends on acss_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): mode 0 starts a run with channel_mask, mode 1
//   hands in a finished conversion with its sample. Output channel (out_valid /
//   out_stall): one result transaction per input transaction, telling which channel
//   to convert next, where to store the sample and whether every enabled channel
//   has its samples.
//   Accepted input is registered in the output or skid register. One transaction per
//   cycle is sustained while out_stall stays low; the channel pick is a rotate-priority
//   search over the mask and the count of enabled channels a popcount, both inside the
//   single register stage. A skid register behind the output register absorbs one
//   result while the receiver stalls; in_stall rises only when it is occupied.
//   Reset (synchronous, rst high) empties both registers, clears the run state and
//   sets samples_per_channel to 16. The APB port writes samples_per_channel at byte
//   addresses 0 to 3; a count of 0 acts as 1 and values above MAX_SAMPLES saturate.
module adc_channel_scan_sequencer #(
  parameter int CHANNELS    = acss_pkg::DEFAULT_CHANNELS,
  parameter int MAX_SAMPLES = acss_pkg::DEFAULT_MAX_SAMPLES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acss_pkg::PADDR_W-1:0]  paddr,
  input  logic [acss_pkg::PDATA_W-1:0]  pwdata,
  output logic [acss_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [acss_pkg::MASK_W-1:0]   channel_mask,
  input  logic [acss_pkg::SAMPLE_W-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          start_conversion,
  output logic [acss_pkg::CHAN_W-1:0]   next_channel,
  output logic                          write_enable,
  output logic [acss_pkg::CHAN_W-1:0]   write_channel,
  output logic [acss_pkg::INDEX_W-1:0]  write_index,
  output logic [acss_pkg::SAMPLE_W-1:0] write_data,
  output logic                          all_ready
);
  import acss_pkg::*;

  localparam int CH_W   = $clog2(CHANNELS);
  localparam int PEND_W = $clog2(CHANNELS + 1);
  localparam int FILL_W = $clog2(MAX_SAMPLES + 1);
  localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_SAMPLES);
  localparam logic [CH_W-1:0]   LAST_CH  = CH_W'(CHANNELS - 1);

  // Configuration register.
  logic [SPC_W-1:0] samples_per_channel;
  logic             cfg_write;

  // Run state.
  logic [CHANNELS-1:0] active_mask, active_mask_next;
  logic [CHANNELS-1:0] full_mask, full_mask_next;
  logic [CH_W-1:0]     current_channel, current_channel_next;
  logic [PEND_W-1:0]   pending_channels, pending_channels_next;
  logic [FILL_W-1:0]   fill_position [CHANNELS];
  logic                fill_clear;
  logic                fill_write;

  // Datapath signals.
  logic                accept;
  logic                out_take;
  result_t             res;
  result_t             out_reg;
  result_t             skid_reg;
  logic                skid_valid;
  logic [CHANNELS-1:0] new_mask;
  logic [PEND_W-1:0]   mask_count;
  logic [CNT_W-1:0]    eff_count;
  logic [CNT_W-1:0]    spc_ext;
  logic [CNT_W-1:0]    pos_ext;
  logic [CNT_W-1:0]    pos_inc;
  logic                becomes_full;

  // First channel after 'from' in rotation order whose bit is set in 'want'.
  function automatic logic [CH_W-1:0] pick_next(input logic [CH_W-1:0] from,
                                               input logic [CHANNELS-1:0] want);
    int unsigned     idx;
    logic [CH_W-1:0] slot;
    logic [CH_W-1:0] sel;
    sel = from;
    for (int k = CHANNELS; k >= 1; k--) begin
      idx = int'(from) + k;
      if (idx >= CHANNELS) begin
        idx = idx - CHANNELS;
      end
      slot = CH_W'(idx);
      if (want[slot]) begin
        sel = slot;
      end
    end
    return sel;
  endfunction

  // ---------------------------------------------------------------- APB port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[PADDR_W-1] == REG_SAMPLES_PER_CHANNEL);
  assign prdata    = (paddr[PADDR_W-1] == REG_SAMPLES_PER_CHANNEL) ?
                     PDATA_W'(samples_per_channel) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_channel <= SPC_RESET;
    end else if (cfg_write) begin
      samples_per_channel <= pwdata[SPC_W-1:0];
    end
  end

  // ---------------------------------------------------------------- handshake
  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  // ---------------------------------------------------------------- next state
  assign new_mask = channel_mask[CHANNELS-1:0];
  assign spc_ext  = CNT_W'(samples_per_channel);
  assign pos_ext  = CNT_W'(fill_position[current_channel]);
  assign pos_inc  = (pos_ext < MAX_CNT) ? pos_ext + CNT_W'(1) : pos_ext;

  always_comb begin
    if (spc_ext == '0) begin
      eff_count = CNT_W'(1);
    end else if (spc_ext > MAX_CNT) begin
      eff_count = MAX_CNT;
    end else begin
      eff_count = spc_ext;
    end
  end

  always_comb begin
    mask_count = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      mask_count = mask_count + PEND_W'(new_mask[i]);
    end
  end

  assign becomes_full = (pos_inc >= eff_count) && !full_mask[current_channel];

  always_comb begin
    active_mask_next      = active_mask;
    full_mask_next        = full_mask;
    current_channel_next  = current_channel;
    pending_channels_next = pending_channels;
    fill_clear            = 1'b0;
    fill_write            = 1'b0;
    res                   = '0;
    case (mode_t'(mode))
      MODE_START: begin
        active_mask_next      = new_mask;
        full_mask_next        = '0;
        fill_clear            = 1'b1;
        pending_channels_next = mask_count;
        current_channel_next  = LAST_CH;
        if (mask_count != '0) begin
          current_channel_next = pick_next(LAST_CH, new_mask);
          res.start_conversion = 1'b1;
          res.next_channel     = CHAN_W'(current_channel_next);
        end
      end
      MODE_SAMPLE: begin
        if (pending_channels != '0) begin
          fill_write         = 1'b1;
          res.write_enable   = 1'b1;
          res.write_channel  = CHAN_W'(current_channel);
          res.write_index    = INDEX_W'(pos_ext);
          res.write_data     = sample;
          if (becomes_full) begin
            full_mask_next[current_channel] = 1'b1;
            pending_channels_next = pending_channels - PEND_W'(1);
          end
          if (pending_channels_next != '0) begin
            current_channel_next = pick_next(current_channel,
                                             active_mask & ~full_mask_next);
            res.start_conversion = 1'b1;
            res.next_channel     = CHAN_W'(current_channel_next);
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
    res.all_ready = (pending_channels_next == '0);
  end

  // ---------------------------------------------------------------- state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_mask      <= '0;
      full_mask        <= '0;
      current_channel  <= '0;
      pending_channels <= '0;
    end else if (accept) begin
      active_mask      <= active_mask_next;
      full_mask        <= full_mask_next;
      current_channel  <= current_channel_next;
      pending_channels <= pending_channels_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        fill_position[i] <= '0;
      end
    end else if (accept && fill_clear) begin
      for (int i = 0; i < CHANNELS; i++) begin
        fill_position[i] <= '0;
      end
    end else if (accept && fill_write) begin
      fill_position[current_channel] <= FILL_W'(pos_inc);
    end
  end

  // ---------------------------------------------------------------- output and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_reg <= skid_reg;
      end
    end else if (accept) begin
      if (out_valid && !out_take) begin
        skid_reg <= res;
      end else begin
        out_reg <= res;
      end
    end
  end

  assign start_conversion = out_reg.start_conversion;
  assign next_channel     = out_reg.next_channel;
  assign write_enable     = out_reg.write_enable;
  assign write_channel    = out_reg.write_channel;
  assign write_index      = out_reg.write_index;
  assign write_data       = out_reg.write_data;
  assign all_ready        = out_reg.all_ready;

endmodule

@@ rtl/core/acss_checker.sv @@
// Port-level checker for the ADC channel scan sequencer, bound to the top level.
// Depends on acss_pkg and adc_channel_scan_sequencer_macros.svh.
`timescale 1ns / 1ps
`include "adc_channel_scan_sequencer_macros.svh"

module acss_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          start_conversion,
  input logic [acss_pkg::CHAN_W-1:0]   next_channel,
  input logic                          write_enable,
  input logic [acss_pkg::CHAN_W-1:0]   write_channel,
  input logic [acss_pkg::INDEX_W-1:0]  write_index,
  input logic [acss_pkg::SAMPLE_W-1:0] write_data,
  input logic                          all_ready
);
  import acss_pkg::*;

  result_t payload;
  logic    in_take;
  logic    out_wait;
  logic    out_start;
  logic    out_idle;
  logic    idle_zero;

  assign payload   = {start_conversion, next_channel, write_enable, write_channel,
                      write_index, write_data, all_ready};
  assign in_take   = in_valid && !in_stall;
  assign out_wait  = out_valid && out_stall;
  assign out_start = out_valid && start_conversion;
  assign out_idle  = out_valid && !write_enable;
  assign idle_zero = (write_channel == '0) && (write_index == '0) && (write_data == '0);

  // An accepted transaction always shows a result in the following cycle.
  `ACSS_ASSERT_NEXT(a_accept_gives_result, clk, rst, in_take, out_valid, "no result after accept")

  // A conversion is only requested while some channel still needs samples.
  `ACSS_ASSERT_SAME(a_start_not_ready, clk, rst, out_start, !all_ready, "start while all ready")

  // Write fields are zero whenever nothing is stored.
  `ACSS_ASSERT_SAME(a_idle_write_zero, clk, rst, out_idle, idle_zero, "write fields set, no write")

  // A stalled result holds its whole payload.
  `ACSS_ASSERT_NEXT(a_stall_holds, clk, rst, out_wait, out_valid && $stable(payload), "payload moved")

endmodule

bind adc_channel_scan_sequencer acss_checker u_acss_checker (.*);
